@@ hdl/meqs_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// meqs_pkg
// Shared types and constants for the mesh element quality statistics block.
// -----------------------------------------------------------------------------
package meqs_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned AreaW   = 48;
  localparam int unsigned EdgeW   = 25;
  localparam int unsigned AspectW = 24;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ProdW   = 50;  // 25 x 25 signed product
  localparam int unsigned SumW    = 51;  // shoelace accumulator

  // Configuration register index
  localparam logic [0:0] RegTriangleMode = 1'b0;

  typedef struct packed {
    logic                     new_mesh;
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
  } meqs_in_t;

  typedef struct packed {
    logic [AreaW-1:0]   least_area;
    logic [EdgeW-1:0]   shortest_edge;
    logic [EdgeW-1:0]   longest_edge;
    logic [AspectW-1:0] worst_aspect;
    logic [CountW-1:0]  degenerate_count;
  } meqs_out_t;

endpackage

@@ hdl/meqs_isqrt.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// meqs_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module meqs_isqrt import meqs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] rad_i,
  output logic             done_o,
  output logic [EdgeW-1:0] root_o
);

  localparam int unsigned RemW = EdgeW + 3;
  localparam int unsigned CntW = $clog2(EdgeW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [EdgeW-1:0] root_q, root_d;
  logic [RemW-1:0]  rem_sh, trial;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], rad_q[ProdW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[ProdW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[EdgeW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[EdgeW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(EdgeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/mesh_element_quality_stats.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mesh_element_quality_stats
// Running area, edge length and aspect ratio statistics over mesh elements.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one element per
//   item: three or four Q16.8 corners and a new_mesh flag that clears the
//   running statistics first. Output channel (out_valid_o / out_ready_i /
//   out_data_o) returns one item per element with the updated statistics.
//   triangle_mode sits at APB address 0; write it only while idle.
// Sequencing:
//   Per edge: products on one shared multiplier, then the shared square-root
//   unit, plus an update step. Then a restoring divide when the shortest edge
//   is nonzero, and one final update. The input is not ready while an element
//   is in work.
// Reset clears the statistics (minimums to all ones) and triangle_mode.
// A stalled receiver holds the result; a finished element then waits in its
// update step until the output register frees.
// -----------------------------------------------------------------------------
module mesh_element_quality_stats import meqs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  meqs_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output meqs_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NumW  = EdgeW + FRAC_BITS;
  localparam int unsigned DCntW = $clog2(NumW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       tri_q;

  logic signed [CoordW-1:0] cx_q [4];
  logic signed [CoordW-1:0] cy_q [4];
  logic [1:0]               edge_q, edge_d, nxt;
  logic [2:0]               step_q, step_d;
  logic signed [SumW-1:0]   s_q, s_d;
  logic [ProdW-1:0]         sq_q, sq_d;
  logic signed [ProdW-1:0]  mul_q;
  logic signed [EdgeW-1:0]  op_a, op_b, dx, dy;
  logic [EdgeW-1:0]         emin_q, emin_d, emax_q, emax_d, emin_nw, emax_nw;
  logic                     last_edge;

  logic [NumW-1:0]   dnum_q, dnum_d;
  logic [EdgeW:0]    drem_q, drem_d, drem_sh;
  logic [DCntW-1:0]  dcnt_q, dcnt_d;
  logic              rok_q, rok_d;

  logic [AreaW-1:0]   area_lo_q, area_lo_d;
  logic [EdgeW-1:0]   edge_lo_q, edge_lo_d, edge_hi_q, edge_hi_d;
  logic [AspectW-1:0] max_asp_q, max_asp_d, ratio;
  logic [CountW-1:0]  deg_q, deg_d;
  logic [SumW-1:0]    mag, half;
  logic [AreaW-1:0]   area;

  logic       out_valid_q, out_valid_d;
  meqs_out_t  out_q, out_d;
  logic       sq_start, sq_done;
  logic [ProdW-1:0] sq_rad;
  logic [EdgeW-1:0] sq_root;
  logic       accept, wr_en;

  meqs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // Configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegTriangleMode);
  assign prdata = (paddr[2] == RegTriangleMode) ? {31'd0, tri_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q <= 1'b0;
    end else if (wr_en) begin
      tri_q <= pwdata[0];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Edge operands
  assign last_edge = tri_q ? (edge_q == 2'd2) : (edge_q == 2'd3);
  assign nxt       = last_edge ? 2'd0 : edge_q + 2'd1;
  assign dx = {cx_q[edge_q][CoordW-1], cx_q[edge_q]} - {cx_q[nxt][CoordW-1], cx_q[nxt]};
  assign dy = {cy_q[edge_q][CoordW-1], cy_q[edge_q]} - {cy_q[nxt][CoordW-1], cy_q[nxt]};

  // Shared multiplier operand select
  always_comb begin
    unique case (step_q)
      3'd0: begin
        op_a = EdgeW'(cx_q[edge_q]);
        op_b = EdgeW'(cy_q[nxt]);
      end
      3'd1: begin
        op_a = EdgeW'(cx_q[nxt]);
        op_b = EdgeW'(cy_q[edge_q]);
      end
      3'd2: begin
        op_a = dx;
        op_b = dx;
      end
      default: begin
        op_a = dy;
        op_b = dy;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= op_a * op_b;
  end

  assign emin_nw = (sq_root < emin_q) ? sq_root : emin_q;
  assign emax_nw = (sq_root > emax_q) ? sq_root : emax_q;
  assign sq_rad  = sq_q + ProdW'(mul_q);

  // Area and ratio
  assign mag   = s_q[SumW-1] ? SumW'(-s_q) : SumW'(s_q);
  assign half  = (mag + 1'b1) >> 1;
  assign area  = (|half[SumW-1:AreaW]) ? '1 : half[AreaW-1:0];
  assign ratio = (|dnum_q[NumW-1:AspectW]) ? '1 : dnum_q[AspectW-1:0];
  assign drem_sh = {drem_q[EdgeW-1:0], dnum_q[NumW-1]};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    edge_d     = edge_q;
    step_d     = step_q;
    s_d        = s_q;
    sq_d       = sq_q;
    emin_d     = emin_q;
    emax_d     = emax_q;
    dnum_d     = dnum_q;
    drem_d     = drem_q;
    dcnt_d     = dcnt_q;
    rok_d      = rok_q;
    area_lo_d  = area_lo_q;
    edge_lo_d  = edge_lo_q;
    edge_hi_d  = edge_hi_q;
    max_asp_d  = max_asp_q;
    deg_d      = deg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d      = out_q;
    sq_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EDGE;
          edge_d  = '0;
          step_d  = '0;
          s_d     = '0;
          emin_d  = '1;
          emax_d  = '0;
          rok_d   = 1'b0;
          if (in_data_i.new_mesh) begin
            area_lo_d = '1;
            edge_lo_d = '1;
            edge_hi_d = '0;
            max_asp_d = '0;
            deg_d     = '0;
          end
        end
      end
      S_EDGE: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: ;
          3'd1: s_d = s_q + SumW'(mul_q);
          3'd2: s_d = s_q - SumW'(mul_q);
          3'd3: sq_d = ProdW'(mul_q);
          default: begin
            sq_start = 1'b1;
            state_d  = S_ROOT;
          end
        endcase
      end
      S_ROOT: begin
        if (sq_done) begin
          emin_d = emin_nw;
          emax_d = emax_nw;
          step_d = '0;
          if (!last_edge) begin
            edge_d  = nxt;
            state_d = S_EDGE;
          end else if (emin_nw != '0) begin
            dnum_d  = {emax_nw, FRAC_BITS'(0)};
            drem_d  = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_DIV: begin
        // Restoring divide, one quotient bit per cycle
        if (drem_sh >= {1'b0, emin_q}) begin
          drem_d = drem_sh - {1'b0, emin_q};
          dnum_d = {dnum_q[NumW-2:0], 1'b1};
        end else begin
          drem_d = drem_sh;
          dnum_d = {dnum_q[NumW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCntW'(NumW - 1)) begin
          rok_d   = 1'b1;
          state_d = S_UPD;
        end
      end
      default: begin
        // Fold the element into the statistics once the output frees
        if (!out_valid_q || out_ready_i) begin
          if (area == '0 && deg_q != '1) deg_d = deg_q + 1'b1;
          if (area < area_lo_q) area_lo_d = area;
          if (emin_q < edge_lo_q) edge_lo_d = emin_q;
          if (emax_q > edge_hi_q) edge_hi_d = emax_q;
          if (rok_q && ratio > max_asp_q) max_asp_d = ratio;
          out_d.least_area       = (area < area_lo_q) ? area : area_lo_q;
          out_d.shortest_edge    = (emin_q < edge_lo_q) ? emin_q : edge_lo_q;
          out_d.longest_edge     = (emax_q > edge_hi_q) ? emax_q : edge_hi_q;
          out_d.worst_aspect     = (rok_q && ratio > max_asp_q) ? ratio : max_asp_q;
          out_d.degenerate_count = (area == '0 && deg_q != '1) ? deg_q + 1'b1 : deg_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      edge_q      <= '0;
      step_q      <= '0;
      dcnt_q      <= '0;
      rok_q       <= 1'b0;
      area_lo_q   <= '1;
      edge_lo_q   <= '1;
      edge_hi_q   <= '0;
      max_asp_q   <= '0;
      deg_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      edge_q      <= edge_d;
      step_q      <= step_d;
      dcnt_q      <= dcnt_d;
      rok_q       <= rok_d;
      area_lo_q   <= area_lo_d;
      edge_lo_q   <= edge_lo_d;
      edge_hi_q   <= edge_hi_d;
      max_asp_q   <= max_asp_d;
      deg_q       <= deg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    sq_q   <= sq_d;
    emin_q <= emin_d;
    emax_q <= emax_d;
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    out_q  <= out_d;
    if (accept) begin
      cx_q[0] <= in_data_i.corner0_x;
      cy_q[0] <= in_data_i.corner0_y;
      cx_q[1] <= in_data_i.corner1_x;
      cy_q[1] <= in_data_i.corner1_y;
      cx_q[2] <= in_data_i.corner2_x;
      cy_q[2] <= in_data_i.corner2_y;
      cx_q[3] <= in_data_i.corner3_x;
      cy_q[3] <= in_data_i.corner3_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
